// ===== design/slo_pkg.sv =====
// shared declarations for the shared one-hot lookup evaluator
// types, sizes and the sequencer state encoding; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package slo_pkg;

    localparam int TABLE_BITS_DEF = 8;
    localparam int DATA_W         = 64;
    localparam int KEY_WORD_W     = 64;
    localparam int KEY_WORDS      = 4;

    typedef logic [DATA_W-1:0] data_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINAL
    } seq_state_t;

    // control from the top level to the accumulator
    typedef struct packed {
        logic clear;
        logic en;
        logic gate;
    } acc_ctl_t;

endpackage : slo_pkg

`default_nettype wire

// ===== design/shared_lut_one_hot_eval_top.sv =====
// top level of the shared one-hot lookup evaluator: table memory, sequencer,
// key cell chain and output register; depends on slo_pkg, slo_key_cell, slo_acc
//
// usage
//   input channel s_*: a word with s_op = 0 writes s_table_value into slot
//   s_table_index and gives no result. a word with s_op = 1
//   evaluates one key share against the table and gives one result word on m_*
//   (m_res_share, m_corr_share).
//   an eval walks all 256 offsets, one table read a cycle from the single read
//   port of the synchronous table memory, the key bits shifting out of a chain
//   of four 64-bit cells. the offsets are read in the run state, the drain
//   state lets the last read reach the accumulator, and the final state
//   loads the output register, which also applies the party sign and adds
//   the mask shares. a new word is taken only while the sequencer is idle:
//   one load per cycle then, but no new eval before the last one is done.
//   the output register parts the two sides: while a result waits for m_ready,
//   new loads are taken and a new eval runs; only its final step waits.
//   reset (aresetn low, synchronous) clears the sequencer and the output valid;
//   the table content is not cleared and must be written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module shared_lut_one_hot_eval_top #(
    parameter int TABLE_BITS = slo_pkg::TABLE_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_op,
    input  wire logic                  s_party,
    input  wire logic [TABLE_BITS-1:0] s_x,
    input  wire logic [TABLE_BITS-1:0] s_table_index,
    input  wire slo_pkg::data_t        s_table_value,
    input  wire slo_pkg::data_t        s_key_word0,
    input  wire slo_pkg::data_t        s_key_word1,
    input  wire slo_pkg::data_t        s_key_word2,
    input  wire slo_pkg::data_t        s_key_word3,
    input  wire slo_pkg::data_t        s_res_mask,
    input  wire slo_pkg::data_t        s_corr_mask,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output slo_pkg::data_t             m_res_share,
    output slo_pkg::data_t             m_corr_share
);
    import slo_pkg::*;

    localparam int TABLE_DEPTH = 1 << TABLE_BITS;
    localparam int CNT_W       = TABLE_BITS + 1;

    // op codes of the input word
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // sequencer
    seq_state_t state_reg;
    seq_state_t state_next;

    logic [TABLE_BITS-1:0] k_reg;       // offset being read
    logic [TABLE_BITS-1:0] k_next;
    logic [TABLE_BITS-1:0] x_reg;       // rotation of this eval
    logic                  party_reg;
    data_t                 res_mask_reg;
    data_t                 corr_mask_reg;

    // read pipeline
    logic  rd_vld_reg;
    logic  gate_d_reg;
    data_t rd_data_reg;

    // output register
    logic  m_valid_reg;
    logic  m_valid_next;
    data_t m_res_reg;
    data_t m_corr_reg;

    // fsm outputs
    logic accept_ok;
    logic rd_en;
    logic out_load;
    logic last_k;
    logic out_free;

    logic in_acc;
    logic tab_wr;
    logic eval_start;

    assign last_k     = (k_reg == TABLE_BITS'(TABLE_DEPTH - 1));
    assign out_free   = !m_valid_reg || m_ready;
    assign in_acc     = s_valid && s_ready;
    assign tab_wr     = in_acc && (s_op == OP_LOAD);
    assign eval_start = in_acc && (s_op == OP_EVAL);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (eval_start) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_k) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINAL;
            end
            ST_FINAL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        accept_ok = 1'b0;
        rd_en     = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  accept_ok = 1'b1;
            ST_RUN:   rd_en     = 1'b1;
            ST_DRAIN: ;
            ST_FINAL: out_load  = out_free;
            default:  ;
        endcase
    end

    assign s_ready = accept_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // offset counter, cleared at the start of an eval
    always_comb begin
        k_next = k_reg;
        if (eval_start) begin
            k_next = '0;
        end else if (rd_en) begin
            k_next = k_reg + TABLE_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= '0;
        end else begin
            k_reg <= k_next;
        end
    end

    // eval operands captured at accept
    always_ff @(posedge aclk) begin
        if (eval_start) begin
            x_reg         <= s_x;
            party_reg     <= s_party;
            res_mask_reg  <= s_res_mask;
            corr_mask_reg <= s_corr_mask;
        end
    end

    // key chain: cell 0 holds offsets 0..63, its msb gates the current offset
    data_t key_in  [KEY_WORDS];
    logic  key_msb [KEY_WORDS];

    assign key_in[0] = s_key_word0;
    assign key_in[1] = s_key_word1;
    assign key_in[2] = s_key_word2;
    assign key_in[3] = s_key_word3;

    for (genvar i = 0; i < KEY_WORDS; i++) begin : g_key
        logic chain_in;
        if (i == KEY_WORDS - 1) begin : g_tail
            assign chain_in = 1'b0;
        end else begin : g_link
            assign chain_in = key_msb[i+1];
        end
        slo_key_cell u_cell (
            .aclk      (aclk),
            .load      (eval_start),
            .shift     (rd_en),
            .load_word (key_in[i]),
            .shift_in  (chain_in),
            .shift_out (key_msb[i])
        );
    end

    // table memory, one write and one registered read a cycle
    data_t                 tab_mem [TABLE_DEPTH];
    logic [TABLE_BITS-1:0] rd_addr;

    assign rd_addr = x_reg + k_reg;   // wraps modulo the table depth

    always_ff @(posedge aclk) begin
        if (tab_wr) begin
            tab_mem[s_table_index] <= s_table_value;
        end
        if (rd_en) begin
            rd_data_reg <= tab_mem[rd_addr];
        end
    end

    // gate bit travels alongside the read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        gate_d_reg <= key_msb[0];
    end

    // accumulation of gated entries and set bits
    acc_ctl_t         acc_ctl;
    data_t            acc_sum;
    logic [CNT_W-1:0] acc_cnt;

    assign acc_ctl.clear = eval_start;
    assign acc_ctl.en    = rd_vld_reg;
    assign acc_ctl.gate  = gate_d_reg;

    slo_acc #(
        .CNT_W (CNT_W)
    ) u_acc (
        .aclk (aclk),
        .ctl  (acc_ctl),
        .data (rd_data_reg),
        .sum  (acc_sum),
        .cnt  (acc_cnt)
    );

    // party 1 takes the negated sums: mask - sum instead of mask + sum
    data_t res_final;
    data_t corr_final;
    data_t cnt_ext;

    assign cnt_ext = DATA_W'(acc_cnt);

    always_comb begin
        if (party_reg) begin
            res_final  = res_mask_reg - acc_sum;
            corr_final = corr_mask_reg - cnt_ext;
        end else begin
            res_final  = res_mask_reg + acc_sum;
            corr_final = corr_mask_reg + cnt_ext;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_res_reg  <= res_final;
            m_corr_reg <= corr_final;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_res_share  = m_res_reg;
    assign m_corr_share = m_corr_reg;

endmodule : shared_lut_one_hot_eval_top

`default_nettype wire

// ===== design/slo_key_cell.sv =====
// one cell of the key shift chain: holds one key word, shifts left one bit a cycle while shift is high
// depends on slo_pkg
`timescale 1ns / 1ps
`default_nettype none

module slo_key_cell (
    input  wire logic                           aclk,
    input  wire logic                           load,
    input  wire logic                           shift,
    input  wire logic [slo_pkg::KEY_WORD_W-1:0] load_word,
    input  wire logic                           shift_in,
    output logic                                shift_out
);
    import slo_pkg::*;

    logic [KEY_WORD_W-1:0] word_reg;
    logic [KEY_WORD_W-1:0] word_next;

    always_comb begin
        word_next = word_reg;
        if (load) begin
            word_next = load_word;
        end else if (shift) begin
            word_next = {word_reg[KEY_WORD_W-2:0], shift_in};
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    // msb goes first, to the neighbor or to the gate
    assign shift_out = word_reg[KEY_WORD_W-1];

endmodule : slo_key_cell

`default_nettype wire

// ===== design/slo_acc.sv =====
// accumulator for the gated table sum and the set-bit count
// depends on slo_pkg
`timescale 1ns / 1ps
`default_nettype none

module slo_acc #(
    parameter int CNT_W = slo_pkg::TABLE_BITS_DEF + 1
) (
    input  wire logic              aclk,
    input  wire slo_pkg::acc_ctl_t ctl,
    input  wire slo_pkg::data_t    data,
    output slo_pkg::data_t         sum,
    output logic [CNT_W-1:0]       cnt
);
    import slo_pkg::*;

    data_t            sum_reg;
    data_t            sum_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (ctl.clear) begin
            sum_next = '0;
            cnt_next = '0;
        end else if (ctl.en && ctl.gate) begin
            sum_next = sum_reg + data;
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        cnt_reg <= cnt_next;
    end

    assign sum = sum_reg;
    assign cnt = cnt_reg;

endmodule : slo_acc

`default_nettype wire
